// ===== design/rotation_matrix_to_quaternion_assert.svh =====
// Assertion macros used by the top-level design file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`ifndef SYNTH
`define RMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RMQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RMQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/rmq_pkg.sv =====
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int NUM_W = 17;
    localparam int NLANE = 3;
    localparam int RAD_BITS = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int SQ_N = (RAD_BITS + FRAC_BITS + 1) / 2;
    localparam int DV_W = NUM_W + FRAC_BITS - 1;

    localparam logic [1:0] PIV_TRACE = 2'd0;
    localparam logic [1:0] PIV_X = 2'd1;
    localparam logic [1:0] PIV_Y = 2'd2;
    localparam logic [1:0] PIV_Z = 2'd3;

    typedef struct packed {
        logic [1:0] piv;
        logic flag;
        logic [2*SQ_N-1:0] rad;
        logic [SQ_N+2:0] rem;
        logic [SQ_N-1:0] root;
        logic [NLANE-1:0] neg;
        logic [NLANE-1:0][NUM_W-1:0] mag;
    } t_sq;

    typedef struct packed {
        logic [1:0] piv;
        logic flag;
        logic [SQ_N-1:0] root;
        logic [NLANE-1:0] neg;
        logic [NLANE-1:0][SQ_N:0] rem;
        logic [NLANE-1:0][DV_W-1:0] dq;
    } t_dv;

    // Returns {clipped, value}.
    function automatic logic [16:0] sat16(input logic [DV_W-1:0] mag, input logic neg);
        logic [16:0] res;
        if (neg) begin
            if (mag > DV_W'(32768)) begin
                res = {1'b1, 16'h8000};
            end else begin
                res = {1'b0, 16'(~mag[15:0] + 16'd1)};
            end
        end else begin
            if (mag > DV_W'(32767)) begin
                res = {1'b1, 16'h7fff};
            end else begin
                res = {1'b0, mag[15:0]};
            end
        end
        return res;
    endfunction

endpackage

// ===== design/rotation_matrix_to_quaternion.sv =====
// Channel   Handshake             Payload
// input     i_valid / o_ready     i_m00 .. i_m22
// output    o_valid / i_ready     o_qx o_qy o_qz o_qw o_pivot o_saturated
//
// One transaction is accepted per cycle while o_ready is high.
// The chain is one setup cell, one cell per root bit and one cell per quotient bit,
// plus the output register.
// Reset empties every cell of the chain.
// Each cell takes new data when it is empty or its neighbor takes its data, so a
// stalled output fills the chain before o_ready falls.
`include "rotation_matrix_to_quaternion_assert.svh"

module rotation_matrix_to_quaternion (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_m00,
    input  logic signed [15:0] i_m01,
    input  logic signed [15:0] i_m02,
    input  logic signed [15:0] i_m10,
    input  logic signed [15:0] i_m11,
    input  logic signed [15:0] i_m12,
    input  logic signed [15:0] i_m20,
    input  logic signed [15:0] i_m21,
    input  logic signed [15:0] i_m22,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_qx,
    output logic signed [15:0] o_qy,
    output logic signed [15:0] o_qz,
    output logic signed [15:0] o_qw,
    output logic [1:0]         o_pivot,
    output logic               o_saturated
);

    localparam int N = rmq_pkg::SQ_N;
    localparam int W = rmq_pkg::DV_W;

    logic         w_sq_v   [0:N];
    logic         w_sq_rdy [0:N];
    rmq_pkg::t_sq w_sq_d   [0:N];
    logic         w_dv_v   [0:W];
    logic         w_dv_rdy [0:W];
    rmq_pkg::t_dv w_dv_d   [0:W];

    logic         r_valid;
    logic [15:0]  r_qx, r_qy, r_qz, r_qw;
    logic [1:0]   r_pivot;
    logic         r_sat;
    logic [15:0]  n_qx, n_qy, n_qz, n_qw;
    logic         n_sat;

    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_m00   (i_m00),
        .i_m01   (i_m01),
        .i_m02   (i_m02),
        .i_m10   (i_m10),
        .i_m11   (i_m11),
        .i_m12   (i_m12),
        .i_m20   (i_m20),
        .i_m21   (i_m21),
        .i_m22   (i_m22),
        .o_valid (w_sq_v[0]),
        .o_data  (w_sq_d[0]),
        .i_ready (w_sq_rdy[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_sqrt
        rmq_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sq_v[k]),
            .o_ready (w_sq_rdy[k]),
            .i_data  (w_sq_d[k]),
            .o_valid (w_sq_v[k+1]),
            .o_data  (w_sq_d[k+1]),
            .i_ready (w_sq_rdy[k+1])
        );
    end

    assign w_dv_v[0]   = w_sq_v[N];
    assign w_sq_rdy[N] = w_dv_rdy[0];

    always_comb begin
        w_dv_d[0].piv  = w_sq_d[N].piv;
        w_dv_d[0].flag = w_sq_d[N].flag;
        w_dv_d[0].root = w_sq_d[N].root;
        w_dv_d[0].neg  = w_sq_d[N].neg;
        for (int l = 0; l < rmq_pkg::NLANE; l++) begin
            w_dv_d[0].rem[l] = '0;
            w_dv_d[0].dq[l]  = W'(w_sq_d[N].mag[l]) << (rmq_pkg::FRAC_BITS - 1);
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_div
        rmq_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv_v[k]),
            .o_ready (w_dv_rdy[k]),
            .i_data  (w_dv_d[k]),
            .o_valid (w_dv_v[k+1]),
            .o_data  (w_dv_d[k+1]),
            .i_ready (w_dv_rdy[k+1])
        );
    end

    assign w_dv_rdy[W] = !r_valid || i_ready;

    always_comb begin
        logic [16:0] h, a, b, c;
        logic zero;
        zero = (w_dv_d[W].root == '0);
        h = rmq_pkg::sat16(W'(w_dv_d[W].root >> 1), 1'b0);
        a = rmq_pkg::sat16(w_dv_d[W].dq[0], w_dv_d[W].neg[0]);
        b = rmq_pkg::sat16(w_dv_d[W].dq[1], w_dv_d[W].neg[1]);
        c = rmq_pkg::sat16(w_dv_d[W].dq[2], w_dv_d[W].neg[2]);
        if (zero) begin
            a = '0;
            b = '0;
            c = '0;
        end
        n_sat = w_dv_d[W].flag | h[16] | a[16] | b[16] | c[16];
        unique case (w_dv_d[W].piv)
            rmq_pkg::PIV_TRACE: begin
                n_qx = a[15:0]; n_qy = b[15:0]; n_qz = c[15:0]; n_qw = h[15:0];
            end
            rmq_pkg::PIV_X: begin
                n_qx = h[15:0]; n_qy = b[15:0]; n_qz = c[15:0]; n_qw = a[15:0];
            end
            rmq_pkg::PIV_Y: begin
                n_qx = c[15:0]; n_qy = h[15:0]; n_qz = b[15:0]; n_qw = a[15:0];
            end
            default: begin
                n_qx = b[15:0]; n_qy = c[15:0]; n_qz = h[15:0]; n_qw = a[15:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_dv_rdy[W]) begin
            r_valid <= w_dv_v[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dv_rdy[W] && w_dv_v[W]) begin
            r_qx    <= n_qx;
            r_qy    <= n_qy;
            r_qz    <= n_qz;
            r_qw    <= n_qw;
            r_pivot <= w_dv_d[W].piv;
            r_sat   <= n_sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_qx        = r_qx;
    assign o_qy        = r_qy;
    assign o_qz        = r_qz;
    assign o_qw        = r_qw;
    assign o_pivot     = r_pivot;
    assign o_saturated = r_sat;

    `RMQ_ASSERT_IMP(a_trace_w_pos, i_clk, i_rst_n, o_valid && (o_pivot == rmq_pkg::PIV_TRACE), $signed(o_qw) > 0)
    `RMQ_ASSERT_IMP(a_trace_root, i_clk, i_rst_n, w_dv_v[0] && (w_dv_d[0].piv == rmq_pkg::PIV_TRACE), w_dv_d[0].root != '0)
    `RMQ_ASSERT_NXT(a_out_fill, i_clk, i_rst_n, w_dv_v[W] && !r_valid, o_valid)

endmodule

// ===== design/rmq_front.sv =====
module rmq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_m00,
    input  logic signed [15:0]  i_m01,
    input  logic signed [15:0]  i_m02,
    input  logic signed [15:0]  i_m10,
    input  logic signed [15:0]  i_m11,
    input  logic signed [15:0]  i_m12,
    input  logic signed [15:0]  i_m20,
    input  logic signed [15:0]  i_m21,
    input  logic signed [15:0]  i_m22,
    output logic                o_valid,
    output rmq_pkg::t_sq        o_data,
    input  logic                i_ready
);

    localparam int SW = rmq_pkg::RAD_BITS + 1;

    logic         r_valid;
    rmq_pkg::t_sq r_data;
    rmq_pkg::t_sq n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        logic signed [SW-1:0] d0, d1, d2, tr, rad, one;
        logic signed [rmq_pkg::NUM_W-1:0] n0, n1, n2;
        logic [1:0] piv;
        d0  = SW'(i_m00);
        d1  = SW'(i_m11);
        d2  = SW'(i_m22);
        one = SW'(1) <<< rmq_pkg::FRAC_BITS;
        tr  = d0 + d1 + d2;
        if (tr > 0) begin
            piv = rmq_pkg::PIV_TRACE;
            rad = tr + one;
        end else if (d2 > ((d1 > d0) ? d1 : d0)) begin
            piv = rmq_pkg::PIV_Z;
            rad = d2 - (d0 + d1) + one;
        end else if (d1 > d0) begin
            piv = rmq_pkg::PIV_Y;
            rad = d1 - (d2 + d0) + one;
        end else begin
            piv = rmq_pkg::PIV_X;
            rad = d0 - (d1 + d2) + one;
        end
        unique case (piv)
            rmq_pkg::PIV_TRACE: begin
                n0 = 17'(i_m21) - 17'(i_m12);
                n1 = 17'(i_m02) - 17'(i_m20);
                n2 = 17'(i_m10) - 17'(i_m01);
            end
            rmq_pkg::PIV_X: begin
                n0 = 17'(i_m21) - 17'(i_m12);
                n1 = 17'(i_m10) + 17'(i_m01);
                n2 = 17'(i_m20) + 17'(i_m02);
            end
            rmq_pkg::PIV_Y: begin
                n0 = 17'(i_m02) - 17'(i_m20);
                n1 = 17'(i_m21) + 17'(i_m12);
                n2 = 17'(i_m01) + 17'(i_m10);
            end
            default: begin
                n0 = 17'(i_m10) - 17'(i_m01);
                n1 = 17'(i_m02) + 17'(i_m20);
                n2 = 17'(i_m12) + 17'(i_m21);
            end
        endcase
        n_data.piv  = piv;
        n_data.flag = rad[SW-1];
        if (rad[SW-1]) begin
            rad = '0;
        end
        n_data.rad  = (2*rmq_pkg::SQ_N)'(rad[SW-2:0]) << rmq_pkg::FRAC_BITS;
        n_data.rem  = '0;
        n_data.root = '0;
        n_data.neg  = {n2[rmq_pkg::NUM_W-1], n1[rmq_pkg::NUM_W-1], n0[rmq_pkg::NUM_W-1]};
        n_data.mag[0] = n0[rmq_pkg::NUM_W-1] ? -n0 : n0;
        n_data.mag[1] = n1[rmq_pkg::NUM_W-1] ? -n1 : n1;
        n_data.mag[2] = n2[rmq_pkg::NUM_W-1] ? -n2 : n2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== design/rmq_sqrt_cell.sv =====
module rmq_sqrt_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  rmq_pkg::t_sq i_data,
    output logic         o_valid,
    output rmq_pkg::t_sq o_data,
    input  logic         i_ready
);

    localparam int N = rmq_pkg::SQ_N;

    logic         r_valid;
    rmq_pkg::t_sq r_data;
    rmq_pkg::t_sq n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        logic [N+2:0] rem;
        logic [N+2:0] trial;
        n_data = i_data;
        rem    = {i_data.rem[N:0], i_data.rad[2*N-1 -: 2]};
        trial  = {1'b0, i_data.root, 2'b01};
        n_data.rad = {i_data.rad[2*N-3:0], 2'b00};
        if (rem >= trial) begin
            n_data.rem  = rem - trial;
            n_data.root = {i_data.root[N-2:0], 1'b1};
        end else begin
            n_data.rem  = rem;
            n_data.root = {i_data.root[N-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== design/rmq_div_cell.sv =====
module rmq_div_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  rmq_pkg::t_dv i_data,
    output logic         o_valid,
    output rmq_pkg::t_dv o_data,
    input  logic         i_ready
);

    localparam int N = rmq_pkg::SQ_N;
    localparam int W = rmq_pkg::DV_W;

    logic         r_valid;
    rmq_pkg::t_dv r_data;
    rmq_pkg::t_dv n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        logic [N:0] rem;
        n_data = i_data;
        for (int l = 0; l < rmq_pkg::NLANE; l++) begin
            rem = {i_data.rem[l][N-1:0], i_data.dq[l][W-1]};
            if (rem >= {1'b0, i_data.root}) begin
                n_data.rem[l] = rem - {1'b0, i_data.root};
                n_data.dq[l]  = {i_data.dq[l][W-2:0], 1'b1};
            end else begin
                n_data.rem[l] = rem;
                n_data.dq[l]  = {i_data.dq[l][W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== dv/rotation_matrix_to_quaternion_tb.sv =====
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;

    localparam int  HALF_PERIOD = 6;
    localparam int  STALL_LIMIT = 20000;
    localparam int  DRAIN_CYCLES = 80;
    localparam longint ONE = 64'd1 << rmq_pkg::FRAC_BITS;
    localparam longint HALF = ONE >> 1;

    typedef logic [8:0][15:0] t_matrix;

    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic [1:0]         pivot;
        logic               saturated;
    } t_quat;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_qx, o_qy, o_qz, o_qw;
    logic [1:0]         o_pivot;
    logic               o_saturated;

    t_matrix     sent_matrix;
    t_quat       quat_queue[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    int          quiet_cycles;

    rotation_matrix_to_quaternion uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_m00      (i_m00),
        .i_m01      (i_m01),
        .i_m02      (i_m02),
        .i_m10      (i_m10),
        .i_m11      (i_m11),
        .i_m12      (i_m12),
        .i_m20      (i_m20),
        .i_m21      (i_m21),
        .i_m22      (i_m22),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_qx       (o_qx),
        .o_qy       (o_qy),
        .o_qz       (o_qz),
        .o_qw       (o_qw),
        .o_pivot    (o_pivot),
        .o_saturated(o_saturated)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic longint int_sqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clip_part(longint v, inout logic clipped);
        if (v > 32767) begin
            clipped = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768) begin
            clipped = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic t_quat predict_quat(t_matrix mm);
        longint m[3][3];
        longint q[4];
        longint tr;
        longint rad;
        longint s;
        int     i, j, k;
        logic   clipped;
        logic [1:0] path;
        t_quat  res;
        for (int n = 0; n < 9; n++) m[n / 3][n % 3] = longint'($signed(mm[n]));
        clipped = 1'b0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            s = int_sqrt((tr + ONE) << rmq_pkg::FRAC_BITS);
            path = rmq_pkg::PIV_TRACE;
            q[3] = s >>> 1;
            q[0] = ((m[2][1] - m[1][2]) * HALF) / s;
            q[1] = ((m[0][2] - m[2][0]) * HALF) / s;
            q[2] = ((m[1][0] - m[0][1]) * HALF) / s;
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            rad = (m[i][i] - (m[j][j] + m[k][k])) + ONE;
            if (rad < 0) begin
                rad = 0;
                clipped = 1'b1;
            end
            s = int_sqrt(rad << rmq_pkg::FRAC_BITS);
            case (i)
                0: path = rmq_pkg::PIV_X;
                1: path = rmq_pkg::PIV_Y;
                default: path = rmq_pkg::PIV_Z;
            endcase
            q[i] = s >>> 1;
            if (s != 0) begin
                q[3] = ((m[k][j] - m[j][k]) * HALF) / s;
                q[j] = ((m[j][i] + m[i][j]) * HALF) / s;
                q[k] = ((m[k][i] + m[i][k]) * HALF) / s;
            end else begin
                q[3] = 0;
                q[j] = 0;
                q[k] = 0;
            end
        end
        res.qx = clip_part(q[0], clipped);
        res.qy = clip_part(q[1], clipped);
        res.qz = clip_part(q[2], clipped);
        res.qw = clip_part(q[3], clipped);
        res.pivot = path;
        res.saturated = clipped;
        return res;
    endfunction

    // Expectations are queued when the input transaction is accepted.
    always @(posedge i_clk) begin
        t_quat want;
        t_quat got;
        if (i_rst_n && i_valid && o_ready) quat_queue.push_back(predict_quat(sent_matrix));
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_qx, o_qy, o_qz, o_qw, o_pivot, o_saturated};
            if (quat_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: got %p", got);
            end else begin
                want = quat_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL rotation_matrix_to_quaternion");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            i_ready = 1'b0;
        end else begin
            i_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_matrix(t_matrix mm);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        sent_matrix = mm;
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22} = {
            mm[0], mm[1], mm[2], mm[3], mm[4], mm[5], mm[6], mm[7], mm[8]};
        i_valid = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (quat_queue.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_matrix build(int a0, a1, a2, a3, a4, a5, a6, a7, a8);
        t_matrix mm;
        mm = {a8[15:0], a7[15:0], a6[15:0], a5[15:0], a4[15:0],
              a3[15:0], a2[15:0], a1[15:0], a0[15:0]};
        return mm;
    endfunction

    function automatic t_matrix random_matrix();
        t_matrix mm;
        int      kind;
        kind = $urandom_range(9);
        for (int n = 0; n < 9; n++) begin
            if (kind < 3) begin
                mm[n] = 16'($urandom());
            end else if (kind < 8) begin
                if (n % 4 == 0) mm[n] = 16'($urandom_range(32768) - 16384);
                else mm[n] = 16'($urandom_range(8192) - 4096);
            end else begin
                mm[n] = 16'($urandom_range(64) - 32);
            end
        end
        return mm;
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_matrix(build(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_matrix(build(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send_matrix(build(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        send_matrix(build(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        send_matrix(build(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
        send_matrix(build(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(build(-8192, 100, -200, 300, -8192, 50, 7, 9, -8192));
        send_matrix(build(-16384, 5, 5, 5, -16384, 5, 5, 5, -16384));
        send_matrix(build(-20000, 1, 2, 3, -20000, 4, 5, 6, -30000));
        send_matrix(build(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767,
                          -32768));
        send_matrix(build(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_matrix(build(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768));
        send_matrix(build(1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0));
        send_matrix(build(0, 32767, 32767, 32767, -32768, -32768, 32767, 32767, -32768));
        send_matrix(build(-16384, 32767, 32767, 32767, -16384, 32767, 32767, 32767, 32767));
        send_matrix(build(-5, 0, 0, 0, -5, 0, 0, 0, 10));
        send_matrix(build(-32768, 1000, -1000, 1000, -32768, 1000, -1000, 1000, 32767));
        send_matrix(build(0, 1, 0, 0, 0, 0, 0, 0, 1));
        wait_for_results();
    endtask

    task automatic test_random(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) send_matrix(random_matrix());
        wait_for_results();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge i_clk);
        hold_off_cycles = 300;
        for (int n = 0; n < 90; n++) send_matrix(random_matrix());
        wait_for_results();
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22} = '0;
        sent_matrix = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(0, 0, 130);
        test_random(61, 0, 130);
        test_random(0, 61, 130);
        test_random(38, 38, 130);
        test_backpressure();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && quat_queue.size() == 0) begin
            $display("PASS rotation_matrix_to_quaternion");
        end else begin
            $display("FAIL rotation_matrix_to_quaternion");
        end
        $finish;
    end

endmodule
